[sv/fpa_pkg.sv]
// Shared constants, command codes and types for the fixed-point ALU.
// Used by every module of the ALU; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int FRACTION_BITS      = 8;
    localparam int DATA_W             = 32;
    localparam int CMD_W              = 4;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DATA_W / DIV_BITS_PER_STAGE;
    // Pipeline stage at which the divider quotient appears.
    localparam int PIPE_DEPTH         = DIV_STAGES + 2;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_cmd CMD_ADD      = 4'd0;
    localparam t_cmd CMD_SUB      = 4'd1;
    localparam t_cmd CMD_MUL      = 4'd2;
    localparam t_cmd CMD_DIV      = 4'd3;
    localparam t_cmd CMD_GT       = 4'd4;
    localparam t_cmd CMD_LT       = 4'd5;
    localparam t_cmd CMD_GE       = 4'd6;
    localparam t_cmd CMD_LE       = 4'd7;
    localparam t_cmd CMD_EQ       = 4'd8;
    localparam t_cmd CMD_NE       = 4'd9;
    localparam t_cmd CMD_MIN      = 4'd10;
    localparam t_cmd CMD_MAX      = 4'd11;
    localparam t_cmd CMD_INC      = 4'd12;
    localparam t_cmd CMD_DEC      = 4'd13;
    localparam t_cmd CMD_FROM_INT = 4'd14;
    localparam t_cmd CMD_TO_INT   = 4'd15;

    typedef struct packed {
        logic  sel_mul;
        logic  sel_div;
        t_word res;
        logic  cmp;
        logic  dz;
    } t_side;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] dvs;
        logic              neg;
    } t_div_stage;

endpackage

`default_nettype wire

[sv/fpa_alu.sv]
// Registered part of the ALU: add, subtract, compare, min, max, increment, decrement and conversions;
// it also marks multiply and divide commands and divide by zero. Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpa_alu (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_cmd  i_cmd,
    input  fpa_pkg::t_word i_a,
    input  fpa_pkg::t_word i_b,
    output fpa_pkg::t_side o_side
);
    import fpa_pkg::*;

    t_side n_side;
    t_side r_side;
    t_word w_bias;
    t_word w_round;

    always_comb begin
        n_side  = '0;
        w_bias  = i_a[DATA_W-1] ? t_word'(DATA_W'((1 << FRACTION_BITS) - 1)) : '0;
        w_round = i_a + w_bias;
        unique case (i_cmd)
            CMD_ADD:      n_side.res = i_a + i_b;
            CMD_SUB:      n_side.res = i_a - i_b;
            CMD_MUL:      n_side.sel_mul = 1'b1;
            CMD_DIV: begin
                n_side.sel_div = 1'b1;
                n_side.dz      = (i_b == '0);
            end
            CMD_GT:       n_side.cmp = (i_a > i_b);
            CMD_LT:       n_side.cmp = (i_a < i_b);
            CMD_GE:       n_side.cmp = (i_a >= i_b);
            CMD_LE:       n_side.cmp = (i_a <= i_b);
            CMD_EQ:       n_side.cmp = (i_a == i_b);
            CMD_NE:       n_side.cmp = (i_a != i_b);
            CMD_MIN:      n_side.res = (i_a < i_b) ? i_a : i_b;
            CMD_MAX:      n_side.res = (i_a > i_b) ? i_a : i_b;
            CMD_INC:      n_side.res = i_a + t_word'(1);
            CMD_DEC:      n_side.res = i_a - t_word'(1);
            CMD_FROM_INT: n_side.res = i_a << FRACTION_BITS;
            CMD_TO_INT:   n_side.res = w_round >>> FRACTION_BITS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
        end
    end

    assign o_side = r_side;

endmodule

`default_nettype wire

[sv/fpa_mul.sv]
// Two-stage signed multiplier with the fixed-point realignment shift.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpa_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_word i_a,
    input  fpa_pkg::t_word i_b,
    output fpa_pkg::t_word o_res
);
    import fpa_pkg::*;

    logic signed [2*DATA_W-1:0] r_prod;
    t_word                      r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
            r_res  <= r_prod[FRACTION_BITS +: DATA_W];
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[sv/fpa_div.sv]
// Pipelined restoring divider for the fixed-point divide command.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpa_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_word i_a,
    input  fpa_pkg::t_word i_b,
    output fpa_pkg::t_word o_quot
);
    import fpa_pkg::*;

    function automatic t_div_stage div_step(input t_div_stage s);
        logic [DATA_W:0] w_trial;
        t_div_stage      t;
        t = s;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            w_trial = {t.rem, t.quo[DATA_W-1]};
            t.quo   = {t.quo[DATA_W-2:0], 1'b0};
            if (w_trial >= {1'b0, t.dvs}) begin
                t.rem    = DATA_W'(w_trial - {1'b0, t.dvs});
                t.quo[0] = 1'b1;
            end else begin
                t.rem = w_trial[DATA_W-1:0];
            end
        end
        return t;
    endfunction

    t_word      w_num;
    t_div_stage n_prep;
    t_div_stage r_stage [0:DIV_STAGES];
    t_div_stage n_stage [1:DIV_STAGES];
    t_word      r_quot;

    always_comb begin
        w_num      = {i_a[DATA_W-1-FRACTION_BITS:0], {FRACTION_BITS{1'b0}}};
        n_prep.rem = '0;
        n_prep.quo = w_num[DATA_W-1] ? DATA_W'(-w_num) : DATA_W'(w_num);
        n_prep.dvs = i_b[DATA_W-1] ? DATA_W'(-i_b) : DATA_W'(i_b);
        n_prep.neg = w_num[DATA_W-1] ^ i_b[DATA_W-1];
    end

    always_comb begin
        for (int k = 1; k <= DIV_STAGES; k++) begin
            n_stage[k] = div_step(r_stage[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage[0] <= n_prep;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= r_stage[DIV_STAGES].neg ? t_word'(-r_stage[DIV_STAGES].quo)
                                              : t_word'(r_stage[DIV_STAGES].quo);
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

[sv/fixed_point_alu_core.sv]
// Top level of the signed Q(32-F).F fixed-point ALU with stream ports.
// Depends on fpa_pkg, fpa_alu, fpa_mul and fpa_div.
// The ALU accepts one word per clock cycle while its output is not stalled. Its
// pipeline depth is set by the divider, which resolves two quotient bits
// in each of its sixteen stages, plus input, preparation, sign and output registers.
// All commands share this depth, so results leave in the order their words arrived.
// While a finished result waits on the output, the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_axis_tuser,  // command [3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_value [31:0]
    output logic [1:0]  m_axis_tuser   // compare_true [0], divide_by_zero [1]
);
    import fpa_pkg::*;

    logic  w_en;
    logic  r_valid [0:PIPE_DEPTH];
    t_cmd  r_cmd0;
    t_word r_a0;
    t_word r_b0;
    t_side w_side1;
    t_word w_mul;
    t_word w_quot;
    t_side n_side3;
    t_side r_side [2:PIPE_DEPTH];
    t_word n_res;
    logic  r_out_valid;
    t_word r_out_res;
    logic  r_out_cmp;
    logic  r_out_dz;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PIPE_DEPTH; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_valid[0] <= s_axis_tvalid;
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
            r_out_valid <= r_valid[PIPE_DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd0 <= s_axis_tuser;
            r_a0   <= s_axis_tdata[31:0];
            r_b0   <= s_axis_tdata[63:32];
        end
    end

    fpa_alu u_alu (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cmd  (r_cmd0),
        .i_a    (r_a0),
        .i_b    (r_b0),
        .o_side (w_side1)
    );

    fpa_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_a0),
        .i_b   (r_b0),
        .o_res (w_mul)
    );

    fpa_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (r_a0),
        .i_b    (r_b0),
        .o_quot (w_quot)
    );

    always_comb begin
        n_side3 = r_side[2];
        if (r_side[2].sel_mul) begin
            n_side3.res = w_mul;
        end
    end

    always_comb begin
        if (r_side[PIPE_DEPTH].sel_div && !r_side[PIPE_DEPTH].dz) begin
            n_res = w_quot;
        end else begin
            n_res = r_side[PIPE_DEPTH].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[2] <= w_side1;
            r_side[3] <= n_side3;
            for (int k = 4; k <= PIPE_DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_out_res <= n_res;
            r_out_cmp <= r_side[PIPE_DEPTH].cmp;
            r_out_dz  <= r_side[PIPE_DEPTH].dz;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_res;
    assign m_axis_tuser  = {r_out_dz, r_out_cmp};

endmodule

`default_nettype wire

[sv/fpa_checker.sv]
// Port-level checks for the fixed-point ALU and the bind that attaches them.
// Depends on fixed_point_alu_core.
`timescale 1ns / 1ps
`default_nettype none

module fpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output word dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Output word changed while stalled.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("Comparison and divide-by-zero flags both set.");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 32'd0)
        else $error("Divide by zero gave a non-zero result.");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("Input refused although the output is free.");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the fixed-point ALU core on its stream ports.
// It predicts each result from the command and operands and checks results in order.
// Depends on fpa_pkg and fixed_point_alu_core.
`timescale 1ns / 1ps

module tb;

    import fpa_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RX_HOLD_CYCLES = 90;
    localparam int DRAIN_CYCLES   = 40;
    localparam int IDLE_PERCENT   = 31;

    typedef struct packed {
        t_word value;
        logic  compare_true;
        logic  divide_by_zero;
    } t_alu_result;

    class alu_scoreboard;
        t_alu_result expected_results[$];
        int          error_count;

        function new();
            error_count = 0;
        endfunction

        function t_alu_result compute_alu_result(t_cmd cmd, t_word a, t_word b);
            t_alu_result r;
            longint      wide;
            t_word       dividend;
            r = '0;
            case (cmd)
                CMD_ADD: r.value = a + b;
                CMD_SUB: r.value = a - b;
                CMD_MUL: begin
                    wide    = longint'(a) * longint'(b);
                    wide    = wide >>> FRACTION_BITS;
                    r.value = wide[DATA_W-1:0];
                end
                CMD_DIV: begin
                    if (b == 0) begin
                        r.divide_by_zero = 1'b1;
                    end else begin
                        dividend = a << FRACTION_BITS;
                        wide     = longint'(dividend) / longint'(b);
                        r.value  = wide[DATA_W-1:0];
                    end
                end
                CMD_GT:       r.compare_true = (a > b);
                CMD_LT:       r.compare_true = (a < b);
                CMD_GE:       r.compare_true = (a >= b);
                CMD_LE:       r.compare_true = (a <= b);
                CMD_EQ:       r.compare_true = (a == b);
                CMD_NE:       r.compare_true = (a != b);
                CMD_MIN:      r.value = (a < b) ? a : b;
                CMD_MAX:      r.value = (a > b) ? a : b;
                CMD_INC:      r.value = a + 1;
                CMD_DEC:      r.value = a - 1;
                CMD_FROM_INT: r.value = a << FRACTION_BITS;
                CMD_TO_INT: begin
                    wide    = longint'(a) / (longint'(1) << FRACTION_BITS);
                    r.value = wide[DATA_W-1:0];
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_command(t_cmd cmd, t_word a, t_word b);
            expected_results.push_back(compute_alu_result(cmd, a, b));
        endfunction

        function void check_result(t_word value, logic [1:0] flags);
            t_alu_result exp_r;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %h flags %b",
                         $time, value, flags);
                error_count++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (value !== exp_r.value) begin
                $display("%0t: result_value mismatch, expected %h, actual %h",
                         $time, exp_r.value, value);
                error_count++;
            end
            if (flags[0] !== exp_r.compare_true) begin
                $display("%0t: compare_true mismatch, expected %b, actual %b",
                         $time, exp_r.compare_true, flags[0]);
                error_count++;
            end
            if (flags[1] !== exp_r.divide_by_zero) begin
                $display("%0t: divide_by_zero mismatch, expected %b, actual %b",
                         $time, exp_r.divide_by_zero, flags[1]);
                error_count++;
            end
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;  // operand_a [31:0], operand_b [63:32]
    logic [3:0]  s_axis_tuser;  // command [3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;  // result_value [31:0]
    logic [1:0]  m_axis_tuser;  // compare_true [0], divide_by_zero [1]

    alu_scoreboard sb;
    bit            tx_idle_en;
    bit            rx_idle_en;
    int            rx_hold_reqs;

    fixed_point_alu_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF_NS;
        i_clk = 1'b0;
        #CLK_HALF_NS;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(t_cmd cmd, t_word a, t_word b);
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_command(cmd, a, b);
        @(negedge i_clk);
    endtask

    function automatic t_word random_operand();
        case ($urandom_range(0, 4))
            0: return t_word'($urandom_range(0, 4095)) - 2048;
            1: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return t_word'(1) << FRACTION_BITS;
                    default: return -(t_word'(1) << FRACTION_BITS);
                endcase
            end
            2:       return t_word'($urandom) >>> $urandom_range(0, DATA_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_words(int count);
        t_word a;
        t_word b;
        for (int i = 0; i < count; i++) begin
            a = random_operand();
            case ($urandom_range(0, 9))
                0:       b = a;
                1:       b = '0;
                default: b = random_operand();
            endcase
            send_word(t_cmd'($urandom_range(0, 15)), a, b);
        end
    endtask

    task automatic wait_for_results();
        while (sb.pending_count() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        int hold_left;
        int holds_taken;
        hold_left     = 0;
        holds_taken   = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_taken != rx_hold_reqs) begin
                holds_taken++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        sb            = new();
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        rx_hold_reqs  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ADD;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(CMD_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(CMD_ADD, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_SUB, 32'h8000_0000, 32'h0000_0001);
        send_word(CMD_SUB, 32'h0000_0000, 32'h8000_0000);
        send_word(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
        send_word(CMD_DIV, 32'h0000_0100, 32'h0000_0000);
        // The dividend wraps to the most negative word, so the quotient overflows.
        send_word(CMD_DIV, 32'h0080_0000, 32'hFFFF_FFFF);
        send_word(CMD_DIV, 32'hFFFF_FD00, 32'h0000_0200);
        send_word(CMD_GT,  32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_LT,  32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_GE,  32'h1234_5678, 32'h1234_5678);
        send_word(CMD_LE,  32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_EQ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_NE,  32'h0000_0000, 32'h8000_0000);
        send_word(CMD_MIN, 32'h0000_0500, 32'h0000_0500);
        send_word(CMD_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_DEC, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_FROM_INT, 32'h00FF_FFFF, 32'hA5A5_A5A5);
        send_word(CMD_FROM_INT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_TO_INT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_word(CMD_TO_INT, 32'h8000_0000, 32'h0000_0000);

        send_random_words(180);

        // Hold the output back while words keep coming, so that the pipeline fills.
        tx_idle_en = 1'b0;
        rx_hold_reqs++;
        send_random_words(60);
        tx_idle_en = 1'b1;
        s_axis_tvalid <= 1'b0;
        wait_for_results();

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_words(150);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        send_random_words(135);
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending_count() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
